// ----- design/jds_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// jds_pkg
// Shared types and constants for the job dependency scheduler.
// ----------------------------------------------------------------------------
package jds_pkg;

  localparam int MaxJobs = 32;
  localparam int JobW    = (MaxJobs > 1) ? $clog2(MaxJobs) : 1;
  localparam int CntW    = $clog2(MaxJobs + 1);
  localparam int WordW   = MaxJobs + CntW;

  localparam int FieldW  = 5;
  localparam int CfgW    = 6;
  localparam int PaddrW  = 3;
  localparam int PdataW  = 32;

  localparam logic RegJobCount = 1'b0;

  typedef enum logic [1:0] {
    ModeAdd      = 2'd0,
    ModeComplete = 2'd1,
    ModeQuery    = 2'd2,
    ModeClear    = 2'd3
  } jds_mode_e;

  typedef enum logic [2:0] {
    StIdle,
    StExec,
    StScanRd,
    StScanChk,
    StDone
  } jds_state_e;

endpackage
`default_nettype wire

// ----- design/jds_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// jds_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module jds_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                         wdata_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ----- design/job_dependency_scheduler.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// job_dependency_scheduler
// Dependency matrix, per-job add counts and done marks; each word adds a
// dependency, completes a job, queries or clears, then reports the lowest
// runnable job and an all-done flag.
// ----------------------------------------------------------------------------
//  channel  handshake              payload
//  in       in_valid_i/in_ready_o  mode_i, job_i, dep_i
//  out      out_valid_o/out_ready_i status_o, next_found_o, next_job_o,
//                                  all_done_o
//  cfg      apb psel/penable/...   job_count at byte address 0
//
//  the readiness scan visits at most job_count jobs; the next word can be taken
//  in the cycle the result turns valid; the scan reads one matrix row per
//  read and check state pair through the single ram read port
//  no clearing pass: per-row valid flops reset at once and on clear mode
//  in_ready_o is high only when idle; a held result does not block accept
// ----------------------------------------------------------------------------
module job_dependency_scheduler (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [1:0]                  mode_i,
  input  wire logic [jds_pkg::FieldW-1:0]  job_i,
  input  wire logic [jds_pkg::FieldW-1:0]  dep_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic                             status_o,
  output logic                             next_found_o,
  output logic [jds_pkg::FieldW-1:0]       next_job_o,
  output logic                             all_done_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [jds_pkg::PaddrW-1:0]  paddr,
  input  wire logic [jds_pkg::PdataW-1:0]  pwdata,
  output logic [jds_pkg::PdataW-1:0]       prdata,
  output logic                             pready
);
  import jds_pkg::*;

  jds_state_e            state_q, state_d;
  jds_mode_e             mode_q;
  logic [FieldW-1:0]     job_q, dep_q;
  logic [CfgW-1:0]       job_count_q;
  logic [CfgW-1:0]       n_act;
  logic [JobW-1:0]       scan_q, scan_d;
  logic [MaxJobs-1:0]    valid_q, valid_d;
  logic [MaxJobs-1:0]    done_q, done_d;
  logic                  status_q, status_d;
  logic                  found_q, found_d;
  logic [FieldW-1:0]     next_q, next_d;
  logic                  out_valid_q, out_valid_d;
  logic                  out_status_q, out_found_q, out_all_done_q;
  logic [FieldW-1:0]     out_next_q;
  logic                  out_load;

  logic                  ram_we;
  logic [JobW-1:0]       ram_raddr;
  logic [WordW-1:0]      ram_rdata;
  logic [WordW-1:0]      ram_wdata;

  logic [JobW-1:0]       job_idx, dep_idx, row_idx;
  logic [MaxJobs-1:0]    rd_row, row_new, act_mask;
  logic [CntW-1:0]       rd_cnt, cnt_new;
  logic                  job_bad, dep_bad, cnt_full, job_ready, scan_last, all_done_now;

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegJobCount) ? PdataW'(job_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_count_q <= '0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == RegJobCount)) begin
      job_count_q <= pwdata[CfgW-1:0];
    end
  end

  assign n_act = (32'(job_count_q) > 32'(MaxJobs)) ? '0 : job_count_q;

  always_comb begin
    for (int i = 0; i < MaxJobs; i++) begin
      act_mask[i] = (32'(i) < 32'(n_act));
    end
  end
  assign all_done_now = &(done_q | ~act_mask);

  // shared row check unit
  assign job_idx  = JobW'(job_q);
  assign dep_idx  = JobW'(dep_q);
  assign row_idx  = (state_q == StExec) ? job_idx : scan_q;
  assign rd_row   = valid_q[row_idx] ? ram_rdata[MaxJobs-1:0] : '0;
  assign rd_cnt   = valid_q[row_idx] ? ram_rdata[WordW-1:MaxJobs] : '0;
  assign job_bad  = (CfgW'(job_q) >= n_act);
  assign dep_bad  = (CfgW'(dep_q) >= n_act);
  assign cnt_full = (32'(rd_cnt) >= 32'(MaxJobs));
  assign cnt_new  = rd_cnt + CntW'(1);
  assign job_ready = !done_q[scan_q] && ((rd_row & ~done_q) == '0);
  assign scan_last = ((32'(scan_q) + 32'd1) >= 32'(n_act));

  always_comb begin
    row_new          = rd_row;
    row_new[dep_idx] = 1'b1;
  end
  assign ram_wdata = {cnt_new, row_new};

  jds_ram #(
    .Width (WordW),
    .Depth (MaxJobs)
  ) u_matrix (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (job_idx),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    scan_d      = scan_q;
    valid_d     = valid_q;
    done_d      = done_q;
    status_d    = status_q;
    found_d     = found_q;
    next_d      = next_q;
    out_valid_d = out_valid_q;
    out_load    = 1'b0;
    ram_we      = 1'b0;
    ram_raddr   = scan_q;
    in_ready_o  = 1'b0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        ram_raddr  = JobW'(job_i);
        if (in_valid_i) begin
          status_d = 1'b0;
          found_d  = 1'b0;
          next_d   = '0;
          scan_d   = '0;
          state_d  = StExec;
        end
      end
      StExec: begin
        unique case (mode_q)
          ModeAdd: begin
            if (job_bad || dep_bad || cnt_full) begin
              status_d = 1'b1;
            end else begin
              ram_we           = 1'b1;
              valid_d[job_idx] = 1'b1;
            end
          end
          ModeComplete: begin
            if (job_bad) begin
              status_d = 1'b1;
            end else begin
              done_d[job_idx] = 1'b1;
            end
          end
          ModeQuery: begin
          end
          ModeClear: begin
            valid_d = '0;
            done_d  = '0;
          end
          default: begin
          end
        endcase
        state_d = (n_act == '0) ? StDone : StScanRd;
      end
      StScanRd: begin
        state_d = StScanChk;
      end
      StScanChk: begin
        if (job_ready) begin
          found_d = 1'b1;
          next_d  = FieldW'(scan_q);
          state_d = StDone;
        end else if (scan_last) begin
          state_d = StDone;
        end else begin
          scan_d  = scan_q + JobW'(1);
          state_d = StScanRd;
        end
      end
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      valid_q     <= '0;
      done_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      mode_q <= jds_mode_e'(mode_i);
      job_q  <= job_i;
      dep_q  <= dep_i;
    end
    scan_q   <= scan_d;
    status_q <= status_d;
    found_q  <= found_d;
    next_q   <= next_d;
    if (out_load) begin
      out_status_q   <= status_q;
      out_found_q    <= found_q;
      out_next_q     <= next_q;
      out_all_done_q <= all_done_now;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign next_found_o = out_found_q;
  assign next_job_o   = out_next_q;
  assign all_done_o   = out_all_done_q;

`ifndef NO_ASSERTIONS
  a_done_excludes_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDone) && all_done_now |-> !found_q)
    else $error("runnable job reported while all jobs done");

  a_found_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDone) && found_q |-> (CfgW'(next_q) < n_act))
    else $error("next job outside active range");

  a_clear_wipes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StExec) && (mode_q == ModeClear) |=> (valid_q == '0) && (done_q == '0))
    else $error("clear left stored state behind");

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o && in_valid_i |=> !in_ready_o ##1 !in_ready_o)
    else $error("new word taken during scan");
`endif

endmodule
`default_nettype wire

// ----- bench/tb_job_dependency_scheduler.sv -----
// ----------------------------------------------------------------------------
// tb_job_dependency_scheduler
// Drives add, complete, query and clear words into the scheduler with random
// sender gaps and receiver stalls. A local model of the dependency rows, add
// counts and done bits predicts every result, and the results are checked in
// order. job_count is reprogrammed over APB between runs and read back.
// ----------------------------------------------------------------------------
module tb_job_dependency_scheduler;
  timeunit 1ns;
  timeprecision 1ps;

  import jds_pkg::*;

  localparam int CycleLimit = 1000000;
  localparam logic [PaddrW-1:0] JobCountAddr = PaddrW'(4 * RegJobCount);

  typedef struct packed {
    logic              status;
    logic              found;
    logic [FieldW-1:0] next_job;
    logic              all_done;
  } sched_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [1:0]        mode_i = 2'd0;
  logic [FieldW-1:0] job_i = '0;
  logic [FieldW-1:0] dep_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic              status_o;
  logic              next_found_o;
  logic [FieldW-1:0] next_job_o;
  logic              all_done_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [PaddrW-1:0] paddr = '0;
  logic [PdataW-1:0] pwdata = '0;
  logic [PdataW-1:0] prdata;
  logic              pready;

  job_dependency_scheduler dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .job_i        (job_i),
    .dep_i        (dep_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .next_found_o (next_found_o),
    .next_job_o   (next_job_o),
    .all_done_o   (all_done_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  logic [MaxJobs-1:0] dep_rows [MaxJobs];
  int unsigned        add_cnt [MaxJobs];
  logic [MaxJobs-1:0] done_bits;
  logic [CfgW-1:0]    job_count_q;
  sched_result_t      last_pred;
  sched_result_t      expected_results [$];
  sched_result_t      want;

  int errors = 0;
  int words_sent = 0;
  int results_seen = 0;
  int cfg_writes = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int cycle_count = 0;

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_results.size());
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    errors++;
    $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, exp_val);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result word, next_job", next_job_o, 0);
      end else begin
        want = expected_results.pop_front();
        if (status_o !== want.status) report_mismatch("status", status_o, want.status);
        if (next_found_o !== want.found) report_mismatch("next_found", next_found_o, want.found);
        if (next_job_o !== want.next_job) report_mismatch("next_job", next_job_o, want.next_job);
        if (all_done_o !== want.all_done) report_mismatch("all_done", all_done_o, want.all_done);
      end
    end
  end

  function automatic void clear_schedule();
    for (int i = 0; i < MaxJobs; i++) begin
      dep_rows[i] = '0;
      add_cnt[i] = 0;
    end
    done_bits = '0;
  endfunction

  function automatic sched_result_t predict_schedule(input jds_mode_e mode,
                                                     input logic [FieldW-1:0] job,
                                                     input logic [FieldW-1:0] dep);
    sched_result_t      r;
    int                 n;
    logic [MaxJobs-1:0] mask;
    r = '0;
    n = (job_count_q > MaxJobs) ? 0 : int'(job_count_q);
    case (mode)
      ModeAdd: begin
        if (job >= n || dep >= n) begin
          r.status = 1'b1;
        end else if (add_cnt[job] >= MaxJobs) begin
          r.status = 1'b1;
        end else begin
          dep_rows[job][dep] = 1'b1;
          add_cnt[job]++;
        end
      end
      ModeComplete: begin
        if (job >= n) r.status = 1'b1;
        else done_bits[job] = 1'b1;
      end
      ModeClear: clear_schedule();
      default: ;
    endcase
    for (int i = 0; i < n; i++) begin
      if (!r.found && !done_bits[i] && (dep_rows[i] & ~done_bits) == '0) begin
        r.found = 1'b1;
        r.next_job = FieldW'(i);
      end
    end
    mask = (n >= MaxJobs) ? '1 : ((MaxJobs'(1) << n) - 1'b1);
    r.all_done = ((done_bits & mask) == mask);
    return r;
  endfunction

  task automatic send_word(input jds_mode_e mode, input logic [FieldW-1:0] job,
                           input logic [FieldW-1:0] dep);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= mode;
    job_i <= job;
    dep_i <= dep;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    last_pred = predict_schedule(mode, job, dep);
    expected_results.push_back(last_pred);
    words_sent++;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_xfer(input logic wr, input logic [PdataW-1:0] wdata,
                          output logic [PdataW-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= JobCountAddr;
    pwdata <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_job_count(input int value);
    logic [PdataW-1:0] rd;
    wait_idle();
    apb_xfer(1'b1, PdataW'(value), rd);
    job_count_q = CfgW'(value);
    cfg_writes++;
    apb_xfer(1'b0, '0, rd);
    if (rd !== PdataW'(job_count_q)) report_mismatch("job_count readback", rd, job_count_q);
  endtask

  function automatic logic [FieldW-1:0] pick_index(input int n);
    if (n >= 1 && n <= MaxJobs && $urandom_range(99) < 85) return FieldW'($urandom_range(n - 1));
    return FieldW'($urandom);
  endfunction

  task automatic send_random_add(input int n);
    logic [FieldW-1:0] j;
    logic [FieldW-1:0] d;
    j = pick_index(n);
    d = pick_index(n);
    if (j > 0 && j < n && $urandom_range(99) < 70) d = FieldW'($urandom_range(j - 1));
    send_word(ModeAdd, j, d);
  endtask

  task automatic test_empty_graph();
    set_job_count(0);
    send_word(ModeQuery, '0, '0);
    send_word(ModeAdd, '0, '0);
    send_word(ModeComplete, '0, '0);
    send_word(ModeAdd, '1, '1);
    set_job_count(40);
    send_word(ModeQuery, '0, '0);
    send_word(ModeAdd, 5'd1, 5'd0);
    set_job_count(63);
    send_word(ModeQuery, '1, '1);
    set_job_count(33);
    send_word(ModeComplete, '0, '0);
  endtask

  task automatic test_index_extremes();
    set_job_count(32);
    send_word(ModeClear, '1, '1);
    send_word(ModeAdd, 5'd31, 5'd0);
    send_word(ModeAdd, 5'd0, 5'd31);
    send_word(ModeAdd, 5'd31, 5'd31);
    send_word(ModeQuery, '0, '0);
    send_word(ModeComplete, 5'd0, '0);
    send_word(ModeComplete, 5'd0, '1);
    set_job_count(31);
    send_word(ModeAdd, 5'd31, 5'd0);
    send_word(ModeAdd, 5'd0, 5'd31);
    send_word(ModeComplete, 5'd31, '0);
    send_word(ModeQuery, '0, '0);
    set_job_count(1);
    send_word(ModeQuery, '0, '0);
    set_job_count(32);
    send_word(ModeQuery, '0, '0);
  endtask

  task automatic test_dependency_chain();
    set_job_count(4);
    send_word(ModeClear, '0, '0);
    send_word(ModeAdd, 5'd0, 5'd1);
    send_word(ModeAdd, 5'd1, 5'd2);
    send_word(ModeAdd, 5'd2, 5'd3);
    for (int i = 3; i >= 0; i--) send_word(ModeComplete, FieldW'(i), '0);
    send_word(ModeQuery, '0, '0);
  endtask

  task automatic test_full_dependency_list();
    set_job_count(2);
    send_word(ModeClear, '0, '0);
    repeat (MaxJobs) send_word(ModeAdd, 5'd1, 5'd0);
    send_word(ModeAdd, 5'd1, 5'd0);
    send_word(ModeAdd, 5'd1, 5'd1);
    send_word(ModeComplete, 5'd0, '0);
    send_word(ModeComplete, 5'd1, '0);
    send_word(ModeClear, '0, '0);
    send_word(ModeQuery, '0, '0);
  endtask

  task automatic run_random_phase(input int words, input int idle_pct, input int stall);
    int target;
    int n;
    int r;
    int adds;
    send_idle_pct = idle_pct;
    stall_pct = stall;
    target = words_sent + words;
    while (words_sent < target) begin
      r = $urandom_range(99);
      if (r < 65) n = $urandom_range(8, 1);
      else if (r < 82) n = $urandom_range(31, 9);
      else if (r < 94) n = MaxJobs;
      else if ($urandom_range(1) == 0) n = 0;
      else n = $urandom_range(63, 33);
      set_job_count(n);
      send_word(ModeClear, FieldW'($urandom), FieldW'($urandom));
      adds = (n > MaxJobs) ? 3 : $urandom_range(2 * n + 2, 0);
      repeat (adds) send_random_add(n);
      repeat ((n > MaxJobs) ? 4 : 2 * n + 4) begin
        r = $urandom_range(99);
        if (r < 45) begin
          if (last_pred.found) send_word(ModeComplete, last_pred.next_job, FieldW'($urandom));
          else send_word(ModeQuery, FieldW'($urandom), FieldW'($urandom));
        end else if (r < 60) begin
          send_word(ModeQuery, FieldW'($urandom), FieldW'($urandom));
        end else if (r < 75) begin
          send_word(ModeComplete, pick_index(n), FieldW'($urandom));
        end else if (r < 87) begin
          send_random_add(n);
        end else if (r < 90) begin
          send_word(ModeClear, FieldW'($urandom), FieldW'($urandom));
        end else begin
          send_word(jds_mode_e'($urandom_range(3)), FieldW'($urandom), FieldW'($urandom));
        end
      end
    end
  endtask

  initial begin
    clear_schedule();
    job_count_q = '0;
    last_pred = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_graph();
    test_index_extremes();
    test_dependency_chain();
    test_full_dependency_list();
    run_random_phase(275, 0, 0);
    run_random_phase(275, 56, 0);
    run_random_phase(275, 0, 56);
    run_random_phase(275, 26, 26);

    wait_idle();
    repeat (80) @(posedge clk_i);
    $display("checked %0d results for %0d words over %0d job_count writes", results_seen,
             words_sent, cfg_writes);
    $display("random runs with free flow, sender gaps, receiver stalls and both");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
